// ===== design/assert_macros.svh =====
// Assertion macros shared by the trimmed 3x3 blur RTL.
// Each macro takes the clock and the active-low reset that disables the check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the condition holds, the property must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== design/mtb_pkg.sv =====
// Package for the trimmed 3x3 RGB blur: pixel and result types, sizes and constants.
// It depends on nothing; the top level imports it.
package mtb_pkg;

    localparam int DEF_MAX_SIZE = 4096;
    localparam int CFG_W        = 13;
    localparam int SIZE_RESET   = 512;
    localparam int SIZE_MIN     = 3;
    localparam int POS_W        = 12;
    localparam int FIFO_DEPTH   = 8;
    localparam int SUM_W        = 12;
    localparam int INT_W        = 10;
    localparam int IDX_W        = 4;
    localparam int WIN_N        = 9;
    localparam int DIV7_MUL     = 4682;
    localparam int DIV7_MUL_W   = 13;
    localparam int DIV7_SHIFT   = 15;
    localparam int CH_MAX       = 255;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [INT_W-1:0] val;
    } t_ext;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
        t_pix             pix;
        logic             done;
    } t_res;

    // Left operand is earlier in row-major order; ties for the least go to the later one.
    function automatic t_ext pick_lo(input t_ext a, input t_ext b);
        return (b.val <= a.val) ? b : a;
    endfunction

    // Ties for the greatest go to the earlier one.
    function automatic t_ext pick_hi(input t_ext a, input t_ext b);
        return (b.val > a.val) ? b : a;
    endfunction

endpackage

// ===== design/minmax_trimmed_blur_3x3_rgb_top.sv =====
// Top level of the trimmed 3x3 RGB blur: position counters, line store RAM, window,
// min/max trimming pipeline and result queue. Depends on mtb_pkg, mtb_ram and
// assert_macros.svh.
//
//  Channel   Direction  Handshake                  Payload
//  pixel     in         i_valid / o_stall          i_frame_start, i_red, i_green, i_blue
//  result    out        o_valid / i_stall          o_out_row, o_out_column, o_out_red,
//                                                  o_out_green, o_out_blue, o_frame_done
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_image_size
//
// One pixel is taken every clock while o_stall is low.
// Both line stores share one RAM entry per column, read on transfer and written in the next cycle.
// o_stall rises when eight pixels are in the pipeline or waiting in the result queue.
// Reset is synchronous and clears the counters, the queue and the valid flags; the line
// stores are not cleared, and configuration writes are always ready.
`include "assert_macros.svh"

module minmax_trimmed_blur_3x3_rgb_top
    import mtb_pkg::*;
#(
    parameter int MAX_SIZE = DEF_MAX_SIZE
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_frame_start,
    input  logic [7:0]       i_red,
    input  logic [7:0]       i_green,
    input  logic [7:0]       i_blue,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [POS_W-1:0] o_out_row,
    output logic [POS_W-1:0] o_out_column,
    output logic [7:0]       o_out_red,
    output logic [7:0]       o_out_green,
    output logic [7:0]       o_out_blue,
    output logic             o_frame_done,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_image_size
);

    localparam int CW     = $clog2(MAX_SIZE);
    localparam int SW     = $clog2(MAX_SIZE + 1);
    localparam int RAM_W  = 2 * $bits(t_pix);
    localparam int FPW    = $clog2(FIFO_DEPTH);
    localparam int CNTW   = $clog2(FIFO_DEPTH + 1);
    localparam int PROD_W = SUM_W + DIV7_MUL_W;

    // Configuration and position.
    logic [CFG_W-1:0] r_image_size;
    logic [SW-1:0]    size_eff;
    logic [CW-1:0]    r_row;
    logic [CW-1:0]    r_col;
    logic [CW-1:0]    n_row;
    logic [CW-1:0]    n_col;
    logic [CW-1:0]    c0;
    logic [CW-1:0]    r0;
    logic [CW-1:0]    c1;
    logic [CW:0]      r1w;
    logic [CW-1:0]    r1;
    logic [CW:0]      cn;
    logic [CW:0]      rn;
    logic             wrap_c;
    logic             accept;
    logic             s0_emit;
    logic             s0_done;

    // Stage 1: line store read data.
    logic             r_s1_valid;
    logic             r_s1_emit;
    logic             r_s1_done;
    logic [POS_W-1:0] r_s1_row;
    logic [POS_W-1:0] r_s1_col;
    logic [CW-1:0]    r_s1_addr;
    t_pix             r_s1_pix;
    logic             r_fwd;
    logic [RAM_W-1:0] r_fwd_data;
    logic [RAM_W-1:0] ram_q;
    logic [RAM_W-1:0] s1_q;
    logic [RAM_W-1:0] ram_wdata;
    t_pix             up1;
    t_pix             up2;
    t_pix             r_win [WIN_N];
    t_pix             n_win [WIN_N];

    // Stage 2: intensities and sums.
    logic             r_s2_valid;
    logic             r_s2_done;
    logic [POS_W-1:0] r_s2_row;
    logic [POS_W-1:0] r_s2_col;
    logic [INT_W-1:0] s2_int [WIN_N];
    logic [SUM_W-1:0] s2_sum_r;
    logic [SUM_W-1:0] s2_sum_g;
    logic [SUM_W-1:0] s2_sum_b;

    // Stage 3: per-row extremes.
    logic             r_s3_valid;
    logic             r_s3_done;
    logic [POS_W-1:0] r_s3_row;
    logic [POS_W-1:0] r_s3_col;
    logic [INT_W-1:0] r_s3_int [WIN_N];
    t_pix             r_s3_win [WIN_N];
    logic [SUM_W-1:0] r_s3_sum_r;
    logic [SUM_W-1:0] r_s3_sum_g;
    logic [SUM_W-1:0] r_s3_sum_b;
    t_ext             s3_lo [3];
    t_ext             s3_hi [3];

    // Stage 4: trimming.
    logic             r_s4_valid;
    logic             r_s4_done;
    logic [POS_W-1:0] r_s4_row;
    logic [POS_W-1:0] r_s4_col;
    t_ext             r_s4_lo [3];
    t_ext             r_s4_hi [3];
    t_pix             r_s4_win [WIN_N];
    logic [SUM_W-1:0] r_s4_sum_r;
    logic [SUM_W-1:0] r_s4_sum_g;
    logic [SUM_W-1:0] r_s4_sum_b;
    t_ext             s4_lo;
    t_ext             s4_hi;
    t_pix             p_lo;
    t_pix             p_hi;

    // Stage 5: divide and clamp.
    logic             r_s5_valid;
    logic             r_s5_done;
    logic [POS_W-1:0] r_s5_row;
    logic [POS_W-1:0] r_s5_col;
    logic [SUM_W-1:0] r_s5_trim_r;
    logic [SUM_W-1:0] r_s5_trim_g;
    logic [SUM_W-1:0] r_s5_trim_b;
    logic [PROD_W-1:0] prod_r;
    logic [PROD_W-1:0] prod_g;
    logic [PROD_W-1:0] prod_b;
    logic [INT_W-1:0] q_r;
    logic [INT_W-1:0] q_g;
    logic [INT_W-1:0] q_b;
    t_res             s5_res;

    // Result queue and credit.
    t_res             r_fifo [FIFO_DEPTH];
    logic [FPW-1:0]   r_wr_ptr;
    logic [FPW-1:0]   r_rd_ptr;
    logic [CNTW-1:0]  r_fifo_cnt;
    logic [CNTW-1:0]  r_credit;
    logic             push;
    logic             pop;
    logic             drop;
    t_res             head;

    always_comb begin
        if (r_image_size < CFG_W'(SIZE_MIN)) begin
            size_eff = SW'(SIZE_MIN);
        end else if (32'(r_image_size) > 32'(MAX_SIZE)) begin
            size_eff = SW'(MAX_SIZE);
        end else begin
            size_eff = SW'(r_image_size);
        end
    end

    always_comb begin
        c0     = i_frame_start ? '0 : r_col;
        r0     = i_frame_start ? '0 : r_row;
        wrap_c = 32'(c0) >= 32'(size_eff);
        c1     = wrap_c ? '0 : c0;
        r1w    = wrap_c ? {1'b0, r0} + 1'b1 : {1'b0, r0};
        r1     = (32'(r1w) >= 32'(size_eff)) ? '0 : r1w[CW-1:0];
        cn     = {1'b0, c1} + 1'b1;
        rn     = {1'b0, r1} + 1'b1;
        if (32'(cn) >= 32'(size_eff)) begin
            n_col = '0;
            n_row = (32'(rn) >= 32'(size_eff)) ? '0 : rn[CW-1:0];
        end else begin
            n_col = cn[CW-1:0];
            n_row = r1;
        end
        s0_emit = (32'(r1) >= 32'd2) && (32'(c1) >= 32'd2);
        s0_done = (32'(r1) == 32'(size_eff) - 32'd1) && (32'(c1) == 32'(size_eff) - 32'd1);
    end

    assign accept      = i_valid && !o_stall;
    assign o_stall     = r_credit >= CNTW'(FIFO_DEPTH);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= CFG_W'(SIZE_RESET);
            r_row        <= '0;
            r_col        <= '0;
            r_s1_valid   <= 1'b0;
            r_fwd        <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_image_size <= i_cfg_image_size;
            end
            if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            r_s1_valid <= accept;
            r_fwd      <= accept && r_s1_valid && (c1 == r_s1_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= ram_wdata;
        if (accept) begin
            r_s1_emit <= s0_emit;
            r_s1_done <= s0_done;
            r_s1_row  <= POS_W'(32'(r1) - 32'd1);
            r_s1_col  <= POS_W'(32'(c1) - 32'd1);
            r_s1_addr <= c1;
            r_s1_pix  <= '{red: i_red, green: i_green, blue: i_blue};
        end
    end

    mtb_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_SIZE)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (ram_wdata),
        .i_raddr (c1),
        .o_rdata (ram_q)
    );

    // Each entry holds the row above in its upper half and the row two above in its lower half.
    always_comb begin
        s1_q      = r_fwd ? r_fwd_data : ram_q;
        up1       = t_pix'(s1_q[RAM_W-1 -: $bits(t_pix)]);
        up2       = t_pix'(s1_q[$bits(t_pix)-1:0]);
        ram_wdata = {r_s1_pix, up1};
        for (int k = 0; k < 3; k++) begin
            n_win[3*k]     = r_win[3*k + 1];
            n_win[3*k + 1] = r_win[3*k + 2];
        end
        n_win[2] = up2;
        n_win[5] = up1;
        n_win[8] = r_s1_pix;
    end

    assign drop = r_s1_valid && !r_s1_emit;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_win <= n_win;
        end
        r_s2_done <= r_s1_done;
        r_s2_row  <= r_s1_row;
        r_s2_col  <= r_s1_col;
    end

    always_comb begin
        s2_sum_r = '0;
        s2_sum_g = '0;
        s2_sum_b = '0;
        for (int k = 0; k < WIN_N; k++) begin
            s2_int[k] = INT_W'(r_win[k].red) + INT_W'(r_win[k].green)
                      + INT_W'(r_win[k].blue);
            s2_sum_r  = s2_sum_r + SUM_W'(r_win[k].red);
            s2_sum_g  = s2_sum_g + SUM_W'(r_win[k].green);
            s2_sum_b  = s2_sum_b + SUM_W'(r_win[k].blue);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_done  <= r_s2_done;
        r_s3_row   <= r_s2_row;
        r_s3_col   <= r_s2_col;
        r_s3_int   <= s2_int;
        r_s3_win   <= r_win;
        r_s3_sum_r <= s2_sum_r;
        r_s3_sum_g <= s2_sum_g;
        r_s3_sum_b <= s2_sum_b;
    end

    always_comb begin
        for (int g = 0; g < 3; g++) begin
            s3_lo[g] = pick_lo(pick_lo('{idx: IDX_W'(3*g), val: r_s3_int[3*g]},
                                       '{idx: IDX_W'(3*g + 1), val: r_s3_int[3*g + 1]}),
                               '{idx: IDX_W'(3*g + 2), val: r_s3_int[3*g + 2]});
            s3_hi[g] = pick_hi(pick_hi('{idx: IDX_W'(3*g), val: r_s3_int[3*g]},
                                       '{idx: IDX_W'(3*g + 1), val: r_s3_int[3*g + 1]}),
                               '{idx: IDX_W'(3*g + 2), val: r_s3_int[3*g + 2]});
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_done  <= r_s3_done;
        r_s4_row   <= r_s3_row;
        r_s4_col   <= r_s3_col;
        r_s4_lo    <= s3_lo;
        r_s4_hi    <= s3_hi;
        r_s4_win   <= r_s3_win;
        r_s4_sum_r <= r_s3_sum_r;
        r_s4_sum_g <= r_s3_sum_g;
        r_s4_sum_b <= r_s3_sum_b;
    end

    always_comb begin
        s4_lo = pick_lo(pick_lo(r_s4_lo[0], r_s4_lo[1]), r_s4_lo[2]);
        s4_hi = pick_hi(pick_hi(r_s4_hi[0], r_s4_hi[1]), r_s4_hi[2]);
        p_lo  = r_s4_win[s4_lo.idx];
        p_hi  = r_s4_win[s4_hi.idx];
    end

    always_ff @(posedge i_clk) begin
        r_s5_done   <= r_s4_done;
        r_s5_row    <= r_s4_row;
        r_s5_col    <= r_s4_col;
        r_s5_trim_r <= r_s4_sum_r - SUM_W'(p_lo.red) - SUM_W'(p_hi.red);
        r_s5_trim_g <= r_s4_sum_g - SUM_W'(p_lo.green) - SUM_W'(p_hi.green);
        r_s5_trim_b <= r_s4_sum_b - SUM_W'(p_lo.blue) - SUM_W'(p_hi.blue);
    end

    // Division by seven is a multiply by a rounded-up reciprocal; exact for sums below 5466.
    always_comb begin
        prod_r = PROD_W'(r_s5_trim_r) * PROD_W'(DIV7_MUL);
        prod_g = PROD_W'(r_s5_trim_g) * PROD_W'(DIV7_MUL);
        prod_b = PROD_W'(r_s5_trim_b) * PROD_W'(DIV7_MUL);
        q_r    = INT_W'(prod_r >> DIV7_SHIFT);
        q_g    = INT_W'(prod_g >> DIV7_SHIFT);
        q_b    = INT_W'(prod_b >> DIV7_SHIFT);
        s5_res.row       = r_s5_row;
        s5_res.column    = r_s5_col;
        s5_res.pix.red   = (q_r > INT_W'(CH_MAX)) ? 8'(CH_MAX) : q_r[7:0];
        s5_res.pix.green = (q_g > INT_W'(CH_MAX)) ? 8'(CH_MAX) : q_g[7:0];
        s5_res.pix.blue  = (q_b > INT_W'(CH_MAX)) ? 8'(CH_MAX) : q_b[7:0];
        s5_res.done      = r_s5_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    assign push = r_s5_valid;
    assign head = r_fifo[r_rd_ptr];
    assign pop  = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= s5_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
            r_credit   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == FIFO_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == FIFO_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            r_fifo_cnt <= r_fifo_cnt + CNTW'(push) - CNTW'(pop);
            r_credit   <= r_credit + CNTW'(accept) - CNTW'(drop) - CNTW'(pop);
        end
    end

    assign o_valid      = r_fifo_cnt != '0;
    assign o_out_row    = head.row;
    assign o_out_column = head.column;
    assign o_out_red    = head.pix.red;
    assign o_out_green  = head.pix.green;
    assign o_out_blue   = head.pix.blue;
    assign o_frame_done = head.done;

    `ASSERT_ALWAYS(a_queue_within_credit, i_clk, i_rst_n, r_fifo_cnt <= r_credit, "queue exceeds credit")
    `ASSERT_ALWAYS(a_credit_bound, i_clk, i_rst_n, r_credit <= CNTW'(FIFO_DEPTH), "credit overflow")
    `ASSERT_ALWAYS(a_fwd_has_write, i_clk, i_rst_n, !r_fwd || r_s1_valid, "forward without write")
    `ASSERT_NEXT(a_push_visible, i_clk, i_rst_n, push, o_valid, "pushed result not visible")

endmodule

// ===== design/mtb_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// It depends on nothing.
module mtb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
